@@ rtl/sbmq_pkg.sv @@
// shared types, constants and helper functions of the shared-buffer multi-queue
package sbmq_pkg;

  localparam int CAPACITY   = 16;
  localparam int QUEUES     = 4;
  localparam int DATA_WIDTH = 32;

  localparam int OUT_W  = 32;
  localparam int QID_W  = 2;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int PTR_W  = $clog2(CAPACITY + 1);
  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  localparam ptr_t NULL_PTR = ptr_t'(CAPACITY);

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic  rd_en;
    slot_t rd_slot;
    logic  lk_we;
    slot_t lk_waddr;
    ptr_t  lk_wdata;
    logic  pl_we;
    slot_t pl_waddr;
    data_t pl_wdata;
  } store_req_t;

  typedef struct packed {
    ptr_t  link;
    data_t data;
  } store_rsp_t;

  function automatic logic is_slot(input ptr_t p);
    return p < NULL_PTR;
  endfunction

  // after reset slot i links to i+1, the last one to null
  function automatic ptr_t link_reset(input slot_t idx);
    return ptr_t'(idx) + ptr_t'(1);
  endfunction

  function automatic logic [OUT_W-1:0] widen_data(input data_t v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    return w[OUT_W-1:0];
  endfunction

  // queue id folded onto the queues present
  function automatic logic [QIDX_W-1:0] queue_index(input logic [QID_W-1:0] id);
    logic [QID_W:0] v;
    v = {1'b0, id};
    for (int i = 0; i < (1 << QID_W) - 1; i++) begin
      if (int'(v) >= QUEUES) begin
        v = (QID_W + 1)'(int'(v) - QUEUES);
      end
    end
    return QIDX_W'(v);
  endfunction

endpackage

@@ rtl/sbmq_store.sv @@
// link and payload memories of the slot store, registered reads
module sbmq_store import sbmq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  store_req_t req,
  output store_rsp_t rsp
);

  ptr_t  link_mem [CAPACITY];
  data_t pl_mem   [CAPACITY];
  logic [CAPACITY-1:0] link_vld;

  ptr_t  link_q;
  logic  link_vld_q;
  slot_t link_idx_q;
  data_t pl_q;

  always_ff @(posedge clk) begin
    if (req.lk_we) begin
      link_mem[req.lk_waddr] <= req.lk_wdata;
    end
    if (req.pl_we) begin
      pl_mem[req.pl_waddr] <= req.pl_wdata;
    end
    if (req.rd_en) begin
      link_q     <= link_mem[req.rd_slot];
      link_vld_q <= link_vld[req.rd_slot];
      link_idx_q <= req.rd_slot;
      pl_q       <= pl_mem[req.rd_slot];
    end
  end

  // unwritten link entries read as their reset chain value
  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (req.lk_we) begin
      link_vld[req.lk_waddr] <= 1'b1;
    end
  end

  assign rsp.link = link_vld_q ? link_q : link_reset(link_idx_q);
  assign rsp.data = pl_q;

`ifndef SYNTHESIS
  a_no_link_overlap: assert property (@(posedge clk) disable iff (rst)
    (req.rd_en && req.lk_we) |-> (req.lk_waddr != req.rd_slot))
    else $error("link read and write hit the same slot");
`endif

endmodule

@@ rtl/shared_buffer_multi_queue.sv @@
// Several FIFO queues sharing one slot store through linked lists and a free list.
// A command has an accept cycle and a completion step: in the accept cycle the head or
// free-list slot is looked up, its link and payload entries are read from the store
// memories, and an enqueue writes its payload and tail link; in the completion step the
// link read comes back and the free-list head, queue head and returned-slot link are
// written. The block takes a new command only once the previous one has completed, so
// commands do not overlap; the completion step waits only while the output register still
// holds an untaken result. No clearing pass is needed after reset: the link store keeps
// a valid bit per slot and unwritten slots read as the initial free-list chain.
module shared_buffer_multi_queue import sbmq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    command,
  input  logic [QID_W-1:0]        queue_id,
  input  logic signed [OUT_W-1:0] data_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] data_out,
  output logic [1:0]              status
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic state;
  logic cmd_r;
  logic [QIDX_W-1:0] q_r;
  slot_t slot_r;
  logic ok_r;
  logic tail_hit;

  ptr_t head_ptr [QUEUES];
  ptr_t tail_ptr [QUEUES];
  ptr_t free_head;

  store_req_t req;
  store_rsp_t rsp;

  logic accept;
  logic done;
  logic [QIDX_W-1:0] qi;
  ptr_t hq;
  ptr_t tq;
  ptr_t slot;
  logic slot_ok;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign done     = (state == S_BUSY) && (!out_valid || !out_stall);

  assign qi      = queue_index(queue_id);
  assign hq      = head_ptr[qi];
  assign tq      = tail_ptr[qi];
  assign slot    = (command == CMD_DEQ) ? hq : free_head;
  assign slot_ok = is_slot(slot);

  always_comb begin
    req          = '0;
    req.rd_en    = accept && slot_ok;
    req.rd_slot  = slot[SLOT_W-1:0];
    req.pl_we    = accept && slot_ok && (command == CMD_ENQ);
    req.pl_waddr = slot[SLOT_W-1:0];
    req.pl_wdata = data_t'(data_in);
    if (state == S_BUSY) begin
      // returned slot goes to the front of the free list
      req.lk_we    = done && ok_r && (cmd_r == CMD_DEQ);
      req.lk_waddr = slot_r;
      req.lk_wdata = free_head;
    end else begin
      // append behind the current tail
      req.lk_we    = accept && slot_ok && (command == CMD_ENQ) && is_slot(hq) && is_slot(tq);
      req.lk_waddr = tq[SLOT_W-1:0];
      req.lk_wdata = slot;
    end
  end

  sbmq_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < QUEUES; i++) begin
        head_ptr[i] <= NULL_PTR;
        tail_ptr[i] <= NULL_PTR;
      end
    end else begin
      if (accept) begin
        state <= S_BUSY;
        if (slot_ok && (command == CMD_ENQ)) begin
          if (!is_slot(hq)) begin
            head_ptr[qi] <= slot;
          end
          tail_ptr[qi] <= slot;
        end
      end else if (done) begin
        state <= S_IDLE;
        if (ok_r) begin
          if (cmd_r == CMD_ENQ) begin
            free_head <= rsp.link;
          end else begin
            // the tail slot is the last in its list, so its successor is null
            head_ptr[q_r] <= tail_hit ? NULL_PTR : rsp.link;
            free_head     <= ptr_t'(slot_r);
          end
        end
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= command;
      q_r      <= qi;
      slot_r   <= slot[SLOT_W-1:0];
      ok_r     <= slot_ok;
      tail_hit <= (hq == tq);
    end
    if (done) begin
      if (ok_r) begin
        status   <= STATUS_OK;
        data_out <= (cmd_r == CMD_DEQ) ? signed'(widen_data(rsp.data)) : '0;
      end else begin
        status   <= (cmd_r == CMD_DEQ) ? STATUS_EMPTY : STATUS_FULL;
        data_out <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_free_head_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= NULL_PTR)
    else $error("free list head out of range");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_BUSY)
    else $error("result beat without a command in flight");

  a_busy_completes: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY && !(out_valid && out_stall)) |=> (state == S_IDLE && out_valid))
    else $error("command did not complete with a free output register");
`endif

endmodule
